FILE: hw/rtl/bmi_pkg.sv
// bmi_pkg: shared types and constants for the banded matrix index block
// word structs, config register indexes and derived arithmetic widths
// depends on nothing
`default_nettype none

package bmi_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int INDEX_WIDTH = 32;
    // products and sums are kept exact at this width, then cut to the index width
    localparam int PROD_WIDTH  = (2 * COORD_WIDTH + 3 > INDEX_WIDTH + 2) ?
                                 (2 * COORD_WIDTH + 3) : (INDEX_WIDTH + 2);
    localparam int CFG_IDX_WIDTH = 2;

    typedef logic [COORD_WIDTH-1:0] t_coord;
    typedef logic [INDEX_WIDTH-1:0] t_index;
    typedef logic [PROD_WIDTH-1:0]  t_prod;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        CFG_ROW_COUNT  = 2'd0,
        CFG_COL_COUNT  = 2'd1,
        CFG_BAND_WIDTH = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        t_coord row_index;
        t_coord col_index;
    } t_bmi_req;

    typedef struct packed {
        logic   in_band;
        t_index linear_index;
    } t_bmi_rsp;

endpackage

`default_nettype wire

FILE: hw/rtl/banded_matrix_index.sv
// banded_matrix_index: k-band linear index generator, top level
// depends on bmi_pkg for word structs, register indexes and widths
`default_nettype none

// usage
//   request channel: drive i_req with (row, column) and raise start; the word
//   is taken at any rising edge where start is high and busy is low. busy is
//   held low, so a new word may be taken in every cycle.
//   result channel: o_valid is high for exactly one cycle with o_rsp holding
//   in_band and linear_index. the receiver cannot stall, and nothing here
//   waits on it: results leave in the order the words came in.
//   config port: i_cfg_we with i_cfg_idx selects row count, column count or
//   band half width, written from i_cfg_wdata; writes to unused indexes are
//   dropped. write only while no word is in flight.
// timing
//   the path is input register, band test and operand prep, four parallel
//   multipliers, then the final adder into the result register; one word
//   per cycle sustained.
// reset
//   synchronous, active low: pipeline empty, row and column count 1, band 0.

module banded_matrix_index (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  bmi_pkg::t_bmi_req      i_req,
    output logic                   o_valid,
    output bmi_pkg::t_bmi_rsp      o_rsp,
    input  wire                    i_cfg_we,
    input  wire [bmi_pkg::CFG_IDX_WIDTH-1:0] i_cfg_idx,
    input  wire [bmi_pkg::COORD_WIDTH-1:0]   i_cfg_wdata
);
    import bmi_pkg::*;

    localparam int CW = COORD_WIDTH;

    // configuration registers
    t_coord r_rows, r_cols, r_band;

    // pipeline valid bits
    logic r_in_vld, r_a_vld, r_b_vld, r_out_vld;

    // input register
    t_bmi_req r_in;

    // stage a: band test and multiplier operands
    logic            r_a_ok;
    t_coord          r_a_left;
    t_coord          r_a_p;
    t_coord          r_a_xmp;
    logic [CW:0]     r_a_db;
    t_coord          r_a_m1;
    logic [CW:0]     r_a_base;

    // stage b: products
    logic            r_b_ok;
    t_prod           r_b_tl, r_b_tr, r_b_pdb, r_b_xpm;
    logic [CW:0]     r_b_base;

    // result register
    t_bmi_rsp        r_out;

    // stage a combinational
    logic            n_a_ok;
    t_coord          n_a_left, n_a_p, n_a_xmp, n_a_m1;
    logic [CW:0]     n_a_db, n_a_base;
    logic [CW+1:0]   x_e, y_e, n_e, m_e, b_e, d_e;
    t_coord          p_lim;
    t_prod           n_idx;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows    <= t_coord'(1);
            r_cols    <= t_coord'(1);
            r_band    <= '0;
            r_in_vld  <= 1'b0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_ROW_COUNT:  r_rows <= i_cfg_wdata;
                    CFG_COL_COUNT:  r_cols <= i_cfg_wdata;
                    CFG_BAND_WIDTH: r_band <= i_cfg_wdata;
                    default: ;
                endcase
            end
            r_in_vld  <= start && !busy;
            r_a_vld   <= r_in_vld;
            r_b_vld   <= r_a_vld;
            r_out_vld <= r_b_vld;
        end
    end

    // band membership and row geometry
    always_comb begin
        x_e = {2'b00, r_in.row_index};
        y_e = {2'b00, r_in.col_index};
        n_e = {2'b00, r_rows};
        m_e = {2'b00, r_cols};
        b_e = {2'b00, r_band};
        d_e = m_e - n_e;

        n_a_ok = (m_e >= n_e) && (x_e < n_e) && (y_e < m_e)
                 && (y_e + b_e >= x_e) && (y_e <= x_e + b_e + d_e);

        // first column of this row, also the triangle size of the left sum
        n_a_left = (r_in.row_index > r_band) ? (r_in.row_index - r_band) : '0;

        // rows below p end on the shifted diagonal, the rest on the last column
        p_lim   = (r_rows > r_band) ? (r_rows - r_band) : '0;
        n_a_p   = (p_lim > r_in.row_index) ? r_in.row_index : p_lim;
        n_a_xmp = r_in.row_index - n_a_p;
        n_a_db  = d_e[CW:0] + {1'b0, r_band};
        n_a_m1  = r_cols - t_coord'(1);
        // row plus offset within the row
        n_a_base = {1'b0, r_in.row_index} + {1'b0, r_in.col_index - n_a_left};
    end

    // final sum: x + tri(p) + p*(d+b) + (x-p)*(m-1) - tri(left) + (y-left)
    always_comb begin
        n_idx = t_prod'(r_b_base) + (r_b_tr >> 1) + r_b_pdb + r_b_xpm - (r_b_tl >> 1);
    end

    // datapath registers, no reset needed
    // k-1 wraps in coordinate width; the product is zero there anyway
    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_in <= i_req;
        end
        r_a_ok   <= n_a_ok;
        r_a_left <= n_a_left;
        r_a_p    <= n_a_p;
        r_a_xmp  <= n_a_xmp;
        r_a_db   <= n_a_db;
        r_a_m1   <= n_a_m1;
        r_a_base <= n_a_base;

        r_b_ok   <= r_a_ok;
        r_b_base <= r_a_base;
        r_b_tl   <= t_prod'(r_a_left) * t_prod'(t_coord'(r_a_left - t_coord'(1)));
        r_b_tr   <= t_prod'(r_a_p) * t_prod'(t_coord'(r_a_p - t_coord'(1)));
        r_b_pdb  <= t_prod'(r_a_p) * t_prod'(r_a_db);
        r_b_xpm  <= t_prod'(r_a_xmp) * t_prod'(r_a_m1);

        r_out.in_band      <= r_b_ok;
        r_out.linear_index <= r_b_ok ? n_idx[INDEX_WIDTH-1:0] : '0;
    end

    assign o_valid = r_out_vld;
    assign o_rsp   = r_out;

endmodule

`default_nettype wire
